// ----- design/qri_pkg.sv -----
// qri_pkg: shared constants, types and the arctangent table for the
// quaternion rate integrator. No dependencies.
package qri_pkg;

  localparam int CORDIC_STEPS  = 24;
  localparam int FRACTION_BITS = 30;
  localparam int GUARD_BITS    = 3;
  localparam int ANGLE_SHIFT   = 57 - FRACTION_BITS;

  // pi in Q2.62, scaled down to the working fraction
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;
  localparam logic signed [35:0] PI_FX   = 36'(PI_Q62 >> (62 - FRACTION_BITS));
  localparam logic signed [35:0] HALF_FX = 36'(PI_Q62 >> (63 - FRACTION_BITS));
  localparam logic signed [35:0] TWO_FX  = 36'(PI_Q62 >> (61 - FRACTION_BITS));

  // register indexes
  localparam logic [2:0] CFG_TIME_STEP = 3'd0;
  localparam logic [2:0] CFG_START_W   = 3'd1;
  localparam logic [2:0] CFG_START_X   = 3'd2;
  localparam logic [2:0] CFG_START_Y   = 3'd3;
  localparam logic [2:0] CFG_START_Z   = 3'd4;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
    32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC, ST_DRAIN, ST_WB, ST_SQRT_N, ST_DIV_U, ST_MOD,
    ST_CORDIC, ST_SQRT_M, ST_DIV_Q, ST_OUT
  } state_t;

  // multiply-accumulate groups
  typedef enum logic [3:0] {
    GRP_SQ, GRP_ANG, GRP_T0, GRP_T1, GRP_T2, GRP_T3,
    GRP_P0, GRP_P1, GRP_P2, GRP_P3, GRP_N2
  } grp_t;

  // start request and completion of an iterative unit
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

// ----- design/quaternion_rate_integrator_top.sv -----
// quaternion_rate_integrator_top: sequencer, shared multiply-accumulate and
// attitude state. Uses qri_pkg, qri_sqrt, qri_div, qri_cordic.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | in_rate_x/y/z, in_restart
//  out     | output    | out_valid/out_stall | out_w/x/y/z, out_zero_rate
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// A rotating request takes two square roots and seven divisions of 32 steps
// each, the CORDIC, the 28 products through the one 36x36 multiplier and
// the 2pi reduction; a zero-rate request skips all but the three squares.
// in_stall is high from acceptance until the result is loaded into the
// output register; the next request may be taken while that result waits.
// Reset (synchronous) restores the control and configuration registers and
// the start attitude; the datapath registers are not reset.
module quaternion_rate_integrator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_rate_x,
  input  logic signed [31:0] in_rate_y,
  input  logic signed [31:0] in_rate_z,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_w,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_zero_rate,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int FB = qri_pkg::FRACTION_BITS;
  localparam logic [63:0] TWO_U = 64'(qri_pkg::TWO_FX);

  qri_pkg::state_t state_r, state_nxt;
  qri_pkg::grp_t   grp_r, grp_nxt;
  logic [1:0] tm_r, tm_nxt, idx_r, idx_nxt;
  logic       launch_r, launch_nxt;

  // configuration
  logic [31:0] dt_r;
  logic signed [31:0] sw_r, sx_r, sy_r, sz_r;

  // working state
  logic signed [31:0] rx_r, rx_nxt, ry_r, ry_nxt, rz_r, rz_nxt;
  logic signed [31:0] a0_r, a0_nxt, a1_r, a1_nxt, a2_r, a2_nxt, a3_r, a3_nxt;
  logic signed [31:0] u0_r, u0_nxt, u1_r, u1_nxt, u2_r, u2_nxt;
  logic signed [35:0] t0_r, t0_nxt, t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt;
  logic signed [33:0] p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic signed [33:0] cg_r, cg_nxt, sg_r, sg_nxt;
  logic signed [35:0] z_r, z_nxt;
  logic       flip_r, flip_nxt, zero_r, zero_nxt;
  logic [31:0] n_r, n_nxt;
  logic [63:0] rad_r, rad_nxt, ang_r, ang_nxt;

  // multiply-accumulate
  logic signed [35:0] mul_a, mul_b;
  logic               mul_neg, mul_last;
  logic signed [71:0] mul_p, prod_r, prod_nxt, acc_r, acc_nxt, acc_sh;
  logic               pneg_r, pneg_nxt, pv_r, pv_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt, out_zero_r, out_zero_nxt;
  logic signed [31:0] ow_r, ow_nxt, ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;

  // units
  qri_pkg::unit_ctl_t sq_ctl, dv_ctl, cd_ctl;
  logic [31:0] sq_root, dv_quo;
  logic [33:0] dv_den;
  logic [63:0] dv_num;
  logic signed [33:0] cd_x, cd_y, c_val;

  // operand selection
  logic signed [31:0] r_sel;
  logic [32:0]        r_mag;
  logic signed [33:0] p_sel;
  logic [34:0]        p_mag;
  logic               q_neg;
  logic signed [31:0] q_signed;
  logic signed [35:0] zr0, zr1, zr2;
  logic               flip_c;

  assign sq_ctl.start = (state_r == qri_pkg::ST_SQRT_N || state_r == qri_pkg::ST_SQRT_M)
                        && launch_r;
  assign dv_ctl.start = (state_r == qri_pkg::ST_DIV_U || state_r == qri_pkg::ST_DIV_Q)
                        && launch_r;
  assign cd_ctl.start = (state_r == qri_pkg::ST_CORDIC) && launch_r;

  qri_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_ctl.start), .rad(rad_r),
    .root(sq_root), .done(sq_ctl.done)
  );

  qri_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_ctl.start), .num(dv_num), .den(dv_den),
    .quo(dv_quo), .done(dv_ctl.done)
  );

  qri_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cd_ctl.start), .z_in(z_r),
    .x_out(cd_x), .y_out(cd_y), .done(cd_ctl.done)
  );

  // product terms of each group
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_neg  = 1'b0;
    mul_last = 1'b0;
    case (grp_r)
      qri_pkg::GRP_SQ: begin
        mul_last = (tm_r == 2'd2);
        case (tm_r)
          2'd0:    begin mul_a = 36'(rx_r); mul_b = 36'(rx_r); end
          2'd1:    begin mul_a = 36'(ry_r); mul_b = 36'(ry_r); end
          default: begin mul_a = 36'(rz_r); mul_b = 36'(rz_r); end
        endcase
      end
      qri_pkg::GRP_ANG: begin
        mul_last = 1'b1;
        mul_a    = 36'(n_r);
        mul_b    = 36'(dt_r);
      end
      qri_pkg::GRP_T0: begin
        mul_last = (tm_r == 2'd2);
        case (tm_r)
          2'd0:    begin mul_a = 36'(a1_r); mul_b = 36'(u0_r); end
          2'd1:    begin mul_a = 36'(a2_r); mul_b = 36'(u1_r); end
          default: begin mul_a = 36'(a3_r); mul_b = 36'(u2_r); end
        endcase
      end
      qri_pkg::GRP_T1: begin
        mul_last = (tm_r == 2'd2);
        case (tm_r)
          2'd0:    begin mul_a = 36'(a0_r); mul_b = 36'(u0_r); end
          2'd1:    begin mul_a = 36'(u1_r); mul_b = 36'(a3_r); end
          default: begin mul_a = 36'(u2_r); mul_b = 36'(a2_r); mul_neg = 1'b1; end
        endcase
      end
      qri_pkg::GRP_T2: begin
        mul_last = (tm_r == 2'd2);
        case (tm_r)
          2'd0:    begin mul_a = 36'(a0_r); mul_b = 36'(u1_r); end
          2'd1:    begin mul_a = 36'(u2_r); mul_b = 36'(a1_r); end
          default: begin mul_a = 36'(u0_r); mul_b = 36'(a3_r); mul_neg = 1'b1; end
        endcase
      end
      qri_pkg::GRP_T3: begin
        mul_last = (tm_r == 2'd2);
        case (tm_r)
          2'd0:    begin mul_a = 36'(a0_r); mul_b = 36'(u2_r); end
          2'd1:    begin mul_a = 36'(u0_r); mul_b = 36'(a2_r); end
          default: begin mul_a = 36'(u1_r); mul_b = 36'(a1_r); mul_neg = 1'b1; end
        endcase
      end
      qri_pkg::GRP_P0: begin
        mul_last = (tm_r == 2'd1);
        mul_a    = (tm_r == 2'd0) ? 36'(cg_r) : 36'(sg_r);
        mul_b    = (tm_r == 2'd0) ? 36'(a0_r) : t0_r;
      end
      qri_pkg::GRP_P1: begin
        mul_last = (tm_r == 2'd1);
        mul_a    = (tm_r == 2'd0) ? 36'(cg_r) : 36'(sg_r);
        mul_b    = (tm_r == 2'd0) ? 36'(a1_r) : t1_r;
      end
      qri_pkg::GRP_P2: begin
        mul_last = (tm_r == 2'd1);
        mul_a    = (tm_r == 2'd0) ? 36'(cg_r) : 36'(sg_r);
        mul_b    = (tm_r == 2'd0) ? 36'(a2_r) : t2_r;
      end
      qri_pkg::GRP_P3: begin
        mul_last = (tm_r == 2'd1);
        mul_a    = (tm_r == 2'd0) ? 36'(cg_r) : 36'(sg_r);
        mul_b    = (tm_r == 2'd0) ? 36'(a3_r) : t3_r;
      end
      qri_pkg::GRP_N2: begin
        mul_last = (tm_r == 2'd3);
        case (tm_r)
          2'd0:    begin mul_a = 36'(p0_r); mul_b = 36'(p0_r); end
          2'd1:    begin mul_a = 36'(p1_r); mul_b = 36'(p1_r); end
          2'd2:    begin mul_a = 36'(p2_r); mul_b = 36'(p2_r); end
          default: begin mul_a = 36'(p3_r); mul_b = 36'(p3_r); end
        endcase
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign acc_sh = acc_r >>> FB;

  // divider operands: rate or rotated component, magnitude scaled up
  always_comb begin
    case (idx_r)
      2'd0:    r_sel = rx_r;
      2'd1:    r_sel = ry_r;
      default: r_sel = rz_r;
    endcase
    case (idx_r)
      2'd0:    p_sel = p0_r;
      2'd1:    p_sel = p1_r;
      2'd2:    p_sel = p2_r;
      default: p_sel = p3_r;
    endcase
    r_mag = r_sel[31] ? 33'(-34'(r_sel)) : 33'(r_sel);
    p_mag = p_sel[33] ? 35'(-35'(p_sel)) : 35'(p_sel);
    case (state_r)
      qri_pkg::ST_DIV_U: begin
        dv_num = 64'(r_mag) << FB;
        dv_den = 34'(n_r);
        q_neg  = r_sel[31];
      end
      qri_pkg::ST_DIV_Q: begin
        dv_num = 64'(p_mag) << FB;
        dv_den = 34'(n_r);
        q_neg  = p_sel[33];
      end
      default: begin
        dv_num = '0;
        dv_den = '0;
        q_neg  = 1'b0;
      end
    endcase
    q_signed = q_neg ? -$signed(dv_quo) : $signed(dv_quo);
  end

  // angle reduction into [-pi/2, pi/2]; ang_r is already below 2pi here
  always_comb begin
    zr0    = 36'(ang_r);
    zr1    = (zr0 > qri_pkg::PI_FX) ? zr0 - qri_pkg::TWO_FX : zr0;
    zr2    = zr1;
    flip_c = 1'b0;
    if (zr1 > qri_pkg::HALF_FX) begin
      zr2    = qri_pkg::PI_FX - zr1;
      flip_c = 1'b1;
    end else if (zr1 < -qri_pkg::HALF_FX) begin
      zr2    = -qri_pkg::PI_FX - zr1;
      flip_c = 1'b1;
    end
  end

  assign c_val = flip_r ? -cd_x : cd_x;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    grp_nxt    = grp_r;
    tm_nxt     = tm_r;
    idx_nxt    = idx_r;
    launch_nxt = 1'b0;
    rx_nxt = rx_r; ry_nxt = ry_r; rz_nxt = rz_r;
    a0_nxt = a0_r; a1_nxt = a1_r; a2_nxt = a2_r; a3_nxt = a3_r;
    u0_nxt = u0_r; u1_nxt = u1_r; u2_nxt = u2_r;
    t0_nxt = t0_r; t1_nxt = t1_r; t2_nxt = t2_r; t3_nxt = t3_r;
    p0_nxt = p0_r; p1_nxt = p1_r; p2_nxt = p2_r; p3_nxt = p3_r;
    cg_nxt = cg_r; sg_nxt = sg_r; z_nxt = z_r; flip_nxt = flip_r;
    zero_nxt = zero_r; n_nxt = n_r; rad_nxt = rad_r; ang_nxt = ang_r;
    prod_nxt = prod_r;
    pneg_nxt = pneg_r;
    pv_nxt   = 1'b0;
    acc_nxt  = acc_r;
    if (pv_r) begin
      acc_nxt = pneg_r ? acc_r - prod_r : acc_r + prod_r;
    end
    out_valid_nxt = out_valid_r && out_stall;
    out_zero_nxt  = out_zero_r;
    ow_nxt = ow_r; ox_nxt = ox_r; oy_nxt = oy_r; oz_nxt = oz_r;

    case (state_r)
      qri_pkg::ST_IDLE: begin
        if (in_valid) begin
          rx_nxt  = in_rate_x;
          ry_nxt  = in_rate_y;
          rz_nxt  = in_rate_z;
          if (in_restart) begin
            a0_nxt = sw_r; a1_nxt = sx_r; a2_nxt = sy_r; a3_nxt = sz_r;
          end
          acc_nxt   = '0;
          grp_nxt   = qri_pkg::GRP_SQ;
          tm_nxt    = '0;
          state_nxt = qri_pkg::ST_MAC;
        end
      end
      qri_pkg::ST_MAC: begin
        prod_nxt = mul_p;
        pneg_nxt = mul_neg;
        pv_nxt   = 1'b1;
        if (mul_last) begin
          state_nxt = qri_pkg::ST_DRAIN;
        end else begin
          tm_nxt = tm_r + 2'd1;
        end
      end
      qri_pkg::ST_DRAIN: begin
        state_nxt = qri_pkg::ST_WB;
      end
      qri_pkg::ST_WB: begin
        acc_nxt   = '0;
        tm_nxt    = '0;
        state_nxt = qri_pkg::ST_MAC;
        case (grp_r)
          qri_pkg::GRP_SQ: begin
            zero_nxt = (acc_r[63:0] == 64'd0);
            rad_nxt  = acc_r[63:0];
            if (acc_r[63:0] == 64'd0) begin
              state_nxt = qri_pkg::ST_OUT;
            end else begin
              state_nxt  = qri_pkg::ST_SQRT_N;
              launch_nxt = 1'b1;
            end
          end
          qri_pkg::GRP_ANG: begin
            ang_nxt   = acc_r[63:0] >> qri_pkg::ANGLE_SHIFT;
            state_nxt = qri_pkg::ST_MOD;
          end
          qri_pkg::GRP_T0: begin t0_nxt = -acc_sh[35:0]; grp_nxt = qri_pkg::GRP_T1; end
          qri_pkg::GRP_T1: begin t1_nxt = acc_sh[35:0];  grp_nxt = qri_pkg::GRP_T2; end
          qri_pkg::GRP_T2: begin t2_nxt = acc_sh[35:0];  grp_nxt = qri_pkg::GRP_T3; end
          qri_pkg::GRP_T3: begin t3_nxt = acc_sh[35:0];  grp_nxt = qri_pkg::GRP_P0; end
          qri_pkg::GRP_P0: begin p0_nxt = acc_sh[33:0];  grp_nxt = qri_pkg::GRP_P1; end
          qri_pkg::GRP_P1: begin p1_nxt = acc_sh[33:0];  grp_nxt = qri_pkg::GRP_P2; end
          qri_pkg::GRP_P2: begin p2_nxt = acc_sh[33:0];  grp_nxt = qri_pkg::GRP_P3; end
          qri_pkg::GRP_P3: begin p3_nxt = acc_sh[33:0];  grp_nxt = qri_pkg::GRP_N2; end
          qri_pkg::GRP_N2: begin
            rad_nxt    = acc_r[63:0];
            state_nxt  = qri_pkg::ST_SQRT_M;
            launch_nxt = 1'b1;
          end
          default: begin
            state_nxt = qri_pkg::ST_IDLE;
          end
        endcase
      end
      qri_pkg::ST_SQRT_N: begin
        if (sq_ctl.done) begin
          n_nxt      = sq_root;
          idx_nxt    = '0;
          state_nxt  = qri_pkg::ST_DIV_U;
          launch_nxt = 1'b1;
        end
      end
      qri_pkg::ST_DIV_U: begin
        if (dv_ctl.done) begin
          case (idx_r)
            2'd0:    u0_nxt = q_signed;
            2'd1:    u1_nxt = q_signed;
            default: u2_nxt = q_signed;
          endcase
          if (idx_r == 2'd2) begin
            grp_nxt   = qri_pkg::GRP_ANG;
            tm_nxt    = '0;
            state_nxt = qri_pkg::ST_MAC;
          end else begin
            idx_nxt    = idx_r + 2'd1;
            launch_nxt = 1'b1;
          end
        end
      end
      // angle mod 2pi: subtract 2pi once a cycle until below it (at most 17 subtractions)
      qri_pkg::ST_MOD: begin
        if (ang_r >= TWO_U) begin
          ang_nxt = ang_r - TWO_U;
        end else begin
          z_nxt      = zr2;
          flip_nxt   = flip_c;
          state_nxt  = qri_pkg::ST_CORDIC;
          launch_nxt = 1'b1;
        end
      end
      qri_pkg::ST_CORDIC: begin
        if (cd_ctl.done) begin
          cg_nxt    = c_val >>> qri_pkg::GUARD_BITS;
          sg_nxt    = cd_y >>> qri_pkg::GUARD_BITS;
          grp_nxt   = qri_pkg::GRP_T0;
          tm_nxt    = '0;
          state_nxt = qri_pkg::ST_MAC;
        end
      end
      qri_pkg::ST_SQRT_M: begin
        if (sq_ctl.done) begin
          n_nxt = sq_root;
          if (sq_root == 32'd0) begin
            a0_nxt = '0; a1_nxt = '0; a2_nxt = '0; a3_nxt = '0;
            state_nxt = qri_pkg::ST_OUT;
          end else begin
            idx_nxt    = '0;
            state_nxt  = qri_pkg::ST_DIV_Q;
            launch_nxt = 1'b1;
          end
        end
      end
      qri_pkg::ST_DIV_Q: begin
        if (dv_ctl.done) begin
          case (idx_r)
            2'd0:    a0_nxt = q_signed;
            2'd1:    a1_nxt = q_signed;
            2'd2:    a2_nxt = q_signed;
            default: a3_nxt = q_signed;
          endcase
          if (idx_r == 2'd3) begin
            state_nxt = qri_pkg::ST_OUT;
          end else begin
            idx_nxt    = idx_r + 2'd1;
            launch_nxt = 1'b1;
          end
        end
      end
      qri_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          ow_nxt = a0_r; ox_nxt = a1_r; oy_nxt = a2_r; oz_nxt = a3_r;
          out_zero_nxt  = zero_r;
          out_valid_nxt = 1'b1;
          state_nxt     = qri_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = qri_pkg::ST_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qri_pkg::ST_IDLE;
      grp_r       <= qri_pkg::GRP_SQ;
      tm_r        <= '0;
      idx_r       <= '0;
      launch_r    <= 1'b0;
      pv_r        <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      a0_r        <= 32'sd1073741824;
      a1_r        <= '0;
      a2_r        <= '0;
      a3_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      grp_r       <= grp_nxt;
      tm_r        <= tm_nxt;
      idx_r       <= idx_nxt;
      launch_r    <= launch_nxt;
      pv_r        <= pv_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      a0_r        <= a0_nxt;
      a1_r        <= a1_nxt;
      a2_r        <= a2_nxt;
      a3_r        <= a3_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rx_r <= rx_nxt; ry_r <= ry_nxt; rz_r <= rz_nxt;
    u0_r <= u0_nxt; u1_r <= u1_nxt; u2_r <= u2_nxt;
    t0_r <= t0_nxt; t1_r <= t1_nxt; t2_r <= t2_nxt; t3_r <= t3_nxt;
    p0_r <= p0_nxt; p1_r <= p1_nxt; p2_r <= p2_nxt; p3_r <= p3_nxt;
    cg_r <= cg_nxt; sg_r <= sg_nxt; z_r <= z_nxt; flip_r <= flip_nxt;
    zero_r <= zero_nxt; n_r <= n_nxt; rad_r <= rad_nxt; ang_r <= ang_nxt;
    prod_r <= prod_nxt; pneg_r <= pneg_nxt;
    ow_r <= ow_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt; oz_r <= oz_nxt;
    out_zero_r <= out_zero_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= 32'd71582788;
      sw_r <= 32'sd1073741824;
      sx_r <= '0;
      sy_r <= '0;
      sz_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qri_pkg::CFG_TIME_STEP: dt_r <= cfg_data;
        qri_pkg::CFG_START_W:   sw_r <= cfg_data;
        qri_pkg::CFG_START_X:   sx_r <= cfg_data;
        qri_pkg::CFG_START_Y:   sy_r <= cfg_data;
        qri_pkg::CFG_START_Z:   sz_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall      = (state_r != qri_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_w         = ow_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_z         = oz_r;
  assign out_zero_rate = out_zero_r;

`ifndef SYNTHESIS
  a_pv_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == qri_pkg::ST_MAC || state_r == qri_pkg::ST_DRAIN))
    else $error("product pending outside accumulate phase");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == qri_pkg::ST_MAC && grp_r == qri_pkg::GRP_SQ))
    else $error("accepted request did not start the rate sum");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == qri_pkg::ST_OUT)
    else $error("result appeared without sequencer output step");

  a_cordic_owner: assert property (@(posedge clk) disable iff (!rst_n)
    cd_ctl.done |-> state_r == qri_pkg::ST_CORDIC)
    else $error("CORDIC finished outside its step");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    dv_ctl.done |-> (state_r == qri_pkg::ST_DIV_U || state_r == qri_pkg::ST_DIV_Q))
    else $error("divider finished outside a divide step");
`endif

endmodule

// ----- design/qri_sqrt.sv -----
// qri_sqrt: iterative floor square root of a 64-bit value, two radicand
// bits per cycle. It uses no package.
module qri_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic [31:0] root,
  output logic        done
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] rad_r, rad_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [35:0] rem_sh, trial;

  // one digit step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_sh   = {rem_r, rad_r[63:62]};
    trial    = {2'b00, root_r, 2'b01};
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = 34'(rem_sh - trial);
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[33:0];
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// ----- design/qri_div.sv -----
// qri_div: restoring divider, one quotient bit per cycle.
// Quotient must fit 32 bits. It uses no package.
module qri_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [33:0] den,
  output logic [31:0] quo,
  output logic        done
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] num_r, num_nxt;
  logic [33:0] den_r, den_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [34:0] sh;

  // shift-subtract step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    sh       = {rem_r, num_r[31]};
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num[31:0];
      den_nxt  = den;
      rem_nxt  = {2'b00, num[63:32]};
      quo_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[30:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = 34'(sh - {1'b0, den_r});
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = sh[33:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ----- design/qri_cordic.sv -----
// qri_cordic: rotation-mode CORDIC from (1, 0), one micro-rotation per
// cycle, gain left in. Uses qri_pkg (step count, arctangent table).
module qri_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [35:0] z_in,
  output logic signed [33:0] x_out,
  output logic signed [33:0] y_out,
  output logic               done
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [35:0] z_r, z_nxt;
  logic signed [33:0] xs, ys;
  logic signed [35:0] step;

  // micro-rotation
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    xs       = x_r >>> cnt_r;
    ys       = y_r >>> cnt_r;
    step     = 36'(qri_pkg::ATAN_Q30[cnt_r] >> (30 - qri_pkg::FRACTION_BITS));
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = 34'(64'd1 << qri_pkg::FRACTION_BITS);
      y_nxt    = '0;
      z_nxt    = z_in;
    end else if (busy_r) begin
      if (!z_r[35]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - step;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + step;
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(qri_pkg::CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign done  = done_r;

endmodule

// ----- verif/tb.sv -----
// tb: self-checking bench for quaternion_rate_integrator_top.
// Uses qri_pkg (register indexes, arctangent table) and a bit-exact predictor.
module tb;

  localparam longint CYCLE_LIMIT = 6000000;
  localparam logic [63:0] PI_Q62_TB = 64'hC90FDAA22168C234;

  typedef struct {
    logic signed [31:0] w, x, y, z;
    logic               zr;
  } att_t;

  // one directed request, with an optional typed-in result
  typedef struct {
    logic               rs;
    logic signed [31:0] rx, ry, rz;
    bit                 chk;
    att_t               res;
  } dir_row_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_restart = 0, out_stall = 0;
  logic signed [31:0] in_rate_x = 0, in_rate_y = 0, in_rate_z = 0;
  logic in_stall, out_valid, out_zero_rate;
  logic signed [31:0] out_w, out_x, out_y, out_z;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  quaternion_rate_integrator_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state: register copies and attitude
  logic [31:0] m_dt, m_start [4];
  longint attitude [4];
  att_t pending_q [$];
  att_t typed_q [$];
  bit typed_chk_q [$];
  int errors = 0, results_seen = 0;
  longint cycles = 0;

  function automatic bit [63:0] mag(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic bit [63:0] isqrt(bit [63:0] v);
    bit [63:0] r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // trunc(v * 2^30 / d) toward zero
  function automatic longint fx_div(longint v, bit [63:0] d);
    bit [63:0] q = (mag(v) << qri_pkg::FRACTION_BITS) / d;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void load_start();
    for (int k = 0; k < 4; k++) attitude[k] = longint'(signed'(m_start[k]));
  endfunction

  // range reduction then CORDIC rotation of (1.0, 0)
  function automatic void rotate_unit(bit [63:0] ang, output longint c, output longint s);
    longint pi_fx = longint'(PI_Q62_TB >> (62 - qri_pkg::FRACTION_BITS));
    longint half_fx = longint'(PI_Q62_TB >> (63 - qri_pkg::FRACTION_BITS));
    bit [63:0] two_fx = PI_Q62_TB >> (61 - qri_pkg::FRACTION_BITS);
    longint z, x, y, nx, stp;
    bit flip = 0;
    z = longint'(ang % two_fx);
    x = longint'(64'd1 << qri_pkg::FRACTION_BITS);
    y = 0;
    if (z > pi_fx) z -= longint'(two_fx);
    if (z > half_fx) begin
      z = pi_fx - z;
      flip = 1;
    end else if (z < -half_fx) begin
      z = -pi_fx - z;
      flip = 1;
    end
    for (int i = 0; i < qri_pkg::CORDIC_STEPS; i++) begin
      stp = longint'({32'd0, qri_pkg::ATAN_Q30[i]});
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= stp;
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += stp;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = y;
  endfunction

  // advance the attitude by one request and return the result it produces
  function automatic att_t integrate(logic signed [31:0] rx, ry, rz, logic rs);
    longint r [3], u [3], t [4], p [4], c, s, cg, sg;
    bit [63:0] sum = 0, norm, n2 = 0, m;
    att_t o;
    if (rs) load_start();
    r[0] = rx; r[1] = ry; r[2] = rz;
    for (int k = 0; k < 3; k++) sum += mag(r[k]) * mag(r[k]);
    if (sum != 0) begin
      norm = isqrt(sum);
      for (int k = 0; k < 3; k++) u[k] = fx_div(r[k], norm);
      rotate_unit((norm * {32'd0, m_dt}) >> qri_pkg::ANGLE_SHIFT, c, s);
      t[0] = -((attitude[1] * u[0] + attitude[2] * u[1] + attitude[3] * u[2])
               >>> qri_pkg::FRACTION_BITS);
      t[1] = (attitude[0] * u[0] + u[1] * attitude[3] - u[2] * attitude[2])
             >>> qri_pkg::FRACTION_BITS;
      t[2] = (attitude[0] * u[1] + u[2] * attitude[1] - u[0] * attitude[3])
             >>> qri_pkg::FRACTION_BITS;
      t[3] = (attitude[0] * u[2] + u[0] * attitude[2] - u[1] * attitude[1])
             >>> qri_pkg::FRACTION_BITS;
      cg = c >>> qri_pkg::GUARD_BITS;
      sg = s >>> qri_pkg::GUARD_BITS;
      for (int k = 0; k < 4; k++) begin
        p[k] = (cg * attitude[k] + sg * t[k]) >>> qri_pkg::FRACTION_BITS;
        n2 += mag(p[k]) * mag(p[k]);
      end
      m = isqrt(n2);
      for (int k = 0; k < 4; k++) attitude[k] = (m == 0) ? 0 : fx_div(p[k], m);
    end
    o.w = attitude[0][31:0];
    o.x = attitude[1][31:0];
    o.y = attitude[2][31:0];
    o.z = attitude[3][31:0];
    o.zr = (sum == 0);
    return o;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("quaternion_rate_integrator_top test failed");
      $finish;
    end
  end

  // receiver: stall pattern redrawn at random, one long hold-off after 400 results
  int hold_left = 0;
  bit hold_done = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 128 == 0) stall_mode = $urandom_range(0, 3);
    if (!hold_done && results_seen >= 400) begin
      hold_done = 1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    att_t e;
    bit typed;
    att_t te;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result w=%0d", out_w);
      end else begin
        e = pending_q.pop_front();
        typed = typed_chk_q.pop_front();
        te = typed_q.pop_front();
        if (typed && (te.w != e.w || te.x != e.x || te.y != e.y || te.z != e.z ||
                      te.zr != e.zr)) e = te;
        if (out_w !== e.w || out_x !== e.x || out_y !== e.y || out_z !== e.z ||
            out_zero_rate !== e.zr) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d %0d %0d %0d z%0b got %0d %0d %0d %0d z%0b",
                     e.w, e.x, e.y, e.z, e.zr, out_w, out_x, out_y, out_z,
                     out_zero_rate);
        end
      end
    end
  end

  // offer one request; valid stays high afterwards until the caller idles
  task automatic send(logic rs, logic signed [31:0] rx, ry, rz, bit chk = 0,
                      att_t res = '{0, 0, 0, 0, 0});
    @(negedge clk);
    in_valid <= 1;
    in_restart <= rs;
    in_rate_x <= rx;
    in_rate_y <= ry;
    in_rate_z <= rz;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(integrate(rx, ry, rz, rs));
    typed_chk_q.push_back(chk);
    typed_q.push_back(res);
  endtask

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 0;
    end
  endtask

  task automatic drain();
    idle(1);
    while (pending_q.size() != 0) @(posedge clk);
    idle(20);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      qri_pkg::CFG_TIME_STEP: m_dt = val;
      qri_pkg::CFG_START_W:   m_start[0] = val;
      qri_pkg::CFG_START_X:   m_start[1] = val;
      qri_pkg::CFG_START_Y:   m_start[2] = val;
      qri_pkg::CFG_START_Z:   m_start[3] = val;
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_rate();
    case ($urandom_range(0, 9))
      0:       return 0;
      1, 2, 3: return $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 26))
                                           : -32'($urandom_range(0, 1 << 26));
      4:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      5:       return 32'($signed($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_run(int n);
    int sent = 0, burst;
    logic signed [31:0] rx, ry, rz;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        rx = rand_rate();
        ry = rand_rate();
        rz = rand_rate();
        if ($urandom_range(0, 15) == 0) begin
          rx = 0; ry = 0; rz = 0;
        end
        send($urandom_range(0, 30) == 0, rx, ry, rz);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 40));
    end
  endtask

  dir_row_t dir_tab [12];
  localparam logic signed [31:0] ONE_Q30 = 32'sh40000000;
  localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  initial begin
    // directed rows: reset attitude held on zero rate, then rate extremes
    dir_tab[0]  = '{0, 0, 0, 0, 1, '{ONE_Q30, 0, 0, 0, 1}};
    dir_tab[1]  = '{0, 32'sh01000000, 0, 0, 0, '{0, 0, 0, 0, 0}};
    dir_tab[2]  = '{0, MINV, MINV, MINV, 0, '{0, 0, 0, 0, 0}};
    dir_tab[3]  = '{0, MAXV, MAXV, MAXV, 0, '{0, 0, 0, 0, 0}};
    dir_tab[4]  = '{0, 1, 0, 0, 0, '{0, 0, 0, 0, 0}};
    dir_tab[5]  = '{0, 0, -1, 0, 0, '{0, 0, 0, 0, 0}};
    dir_tab[6]  = '{0, 0, 0, MAXV, 0, '{0, 0, 0, 0, 0}};
    dir_tab[7]  = '{1, 0, 0, 0, 1, '{ONE_Q30, 0, 0, 0, 1}};
    dir_tab[8]  = '{0, MAXV, 0, MINV, 0, '{0, 0, 0, 0, 0}};
    dir_tab[9]  = '{0, 0, 0, 0, 0, '{0, 0, 0, 0, 0}};
    dir_tab[10] = '{1, -32'sd5000000, 32'sd3000000, 32'sd7, 0, '{0, 0, 0, 0, 0}};
    dir_tab[11] = '{0, 0, MINV, 0, 0, '{0, 0, 0, 0, 0}};

    m_dt = 32'd71582788;
    m_start[0] = ONE_Q30;
    m_start[1] = 0; m_start[2] = 0; m_start[3] = 0;
    load_start();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    foreach (dir_tab[i])
      send(dir_tab[i].rs, dir_tab[i].rx, dir_tab[i].ry, dir_tab[i].rz,
           dir_tab[i].chk, dir_tab[i].res);
    random_run(280);
    drain();

    // zero step, non-unit start, unknown index ignored
    write_reg(qri_pkg::CFG_TIME_STEP, 32'd0);
    write_reg(qri_pkg::CFG_START_W, 32'h7FFFFFFF);
    write_reg(qri_pkg::CFG_START_X, 32'h80000000);
    write_reg(qri_pkg::CFG_START_Y, 32'd0);
    write_reg(qri_pkg::CFG_START_Z, 32'hFFFFFFFF);
    write_reg(3'd7, 32'h12345678);
    send(1, 32'sh01000000, 0, 0);
    random_run(280);
    drain();

    // largest step
    write_reg(qri_pkg::CFG_TIME_STEP, 32'hFFFFFFFF);
    send(1, 0, 32'sh00400000, 0);
    random_run(280);
    drain();

    // zero start quaternion: rotation of nothing stays zero
    write_reg(qri_pkg::CFG_START_W, 32'd0);
    write_reg(qri_pkg::CFG_START_X, 32'd0);
    write_reg(qri_pkg::CFG_START_Z, 32'd0);
    write_reg(qri_pkg::CFG_TIME_STEP, 32'd71582788);
    send(1, 32'sh00100000, 32'sh00100000, 0);
    send(0, 0, 0, 0);
    random_run(280);
    drain();

    // random settings
    repeat (2) begin
      write_reg(qri_pkg::CFG_TIME_STEP, $urandom);
      write_reg(qri_pkg::CFG_START_W, $urandom);
      write_reg(qri_pkg::CFG_START_X, $urandom);
      write_reg(qri_pkg::CFG_START_Y, $urandom);
      write_reg(qri_pkg::CFG_START_Z, $urandom);
      send(1, rand_rate(), rand_rate(), rand_rate());
      random_run(280);
      drain();
    end

    repeat (400) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("quaternion_rate_integrator_top test passed");
    end else begin
      $display("quaternion_rate_integrator_top test failed");
    end
    $finish;
  end

endmodule
